### rtl/mersenne61_rolling_hash_unit_defines.svh
// assertion macros shared by the checker of the rolling hash unit
`ifndef MERSENNE61_ROLLING_HASH_UNIT_DEFINES_SVH
`define MERSENNE61_ROLLING_HASH_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define M61RH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define M61RH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/m61rh_pkg.sv
// shared types, constants and codes of the rolling hash unit
package m61rh_pkg;

  localparam int MAX_LEN_DEFAULT = 1024;
  localparam int HASH_W          = 61;
  localparam int LEN_FIELD_W     = 11;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [HASH_W-1:0] HASH_MOD      = {HASH_W{1'b1}};
  localparam logic [HASH_W-1:0] BASE_RESET    = 61'd131;
  localparam logic [7:0]        SYMBOL_OFFSET = 8'h60;

  // item opcodes
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // address slots carried with a command
  // append: read H[n], read P[n], write slot for n+1
  // query: read H[start], read P[end-start], read H[end]
  localparam int ADDR_H0 = 0;
  localparam int ADDR_P  = 1;
  localparam int ADDR_H1 = 2;
  localparam int ADDR_SLOTS = 3;

  typedef struct packed {
    logic [1:0]             opcode;
    logic [7:0]             symbol;
    logic [LEN_FIELD_W-1:0] start_index;
    logic [LEN_FIELD_W-1:0] end_index;
  } item_t;

  typedef struct packed {
    logic [HASH_W-1:0]      hash_value;
    logic                   error;
    logic [LEN_FIELD_W-1:0] string_length;
  } result_t;

  typedef enum logic [1:0] {
    KIND_PLAIN,
    KIND_APPEND,
    KIND_QUERY
  } cmd_kind_t;

  // classified command handed from front to back
  typedef struct packed {
    cmd_kind_t              kind;
    logic                   error;
    logic [HASH_W-1:0]      value;
    logic [LEN_FIELD_W-1:0] length;
  } cmd_meta_t;

  localparam int META_W = $bits(cmd_meta_t);

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_MUL_H,
    BK_MUL_P,
    BK_FINISH
  } back_state_t;

endpackage

### rtl/m61rh_fifo.sv
// short command queue between front and back
module m61rh_fifo #(
  parameter int DATA_W = m61rh_pkg::META_W,
  parameter int DEPTH  = m61rh_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] wdata,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] rdata,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0]  wptr;
  logic [PTR_W-1:0]  rptr;
  logic [CNT_W-1:0]  count;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

  // status and head
  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= advance(wptr);
      end
      if (pop) begin
        rptr <= advance(rptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wdata;
    end
  end

endmodule

### rtl/m61rh_mulmod.sv
// multiply modulo 2^61-1 with one shared 32x32 multiplier over four partial products
module m61rh_mulmod (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [m61rh_pkg::HASH_W-1:0]  a,
  input  logic [m61rh_pkg::HASH_W-1:0]  b,
  output logic                          done,
  output logic [m61rh_pkg::HASH_W-1:0]  result
);

  localparam logic [2:0] STEP_FIRST = 3'd0;
  localparam logic [2:0] STEP_FOLD  = 3'd5;
  localparam logic [2:0] STEP_LAST  = 3'd6;

  logic                         busy;
  logic [2:0]                   cnt;
  logic [m61rh_pkg::HASH_W-1:0] a_r;
  logic [m61rh_pkg::HASH_W-1:0] b_r;
  logic [31:0]                  op_x;
  logic [31:0]                  op_y;
  logic [63:0]                  prod;
  logic [121:0]                 acc;
  logic [121:0]                 addend;
  logic [61:0]                  fold_s;
  logic [m61rh_pkg::HASH_W-1:0] fold_r;

  // operand halves: low 32 bits and high 29 bits
  always_comb begin
    unique case (cnt[1:0])
      2'd0: begin
        op_x = a_r[31:0];
        op_y = b_r[31:0];
      end
      2'd1: begin
        op_x = a_r[31:0];
        op_y = {3'b000, b_r[60:32]};
      end
      2'd2: begin
        op_x = {3'b000, a_r[60:32]};
        op_y = b_r[31:0];
      end
      default: begin
        op_x = {3'b000, a_r[60:32]};
        op_y = {3'b000, b_r[60:32]};
      end
    endcase
  end

  // weight of the partial product registered one step earlier
  always_comb begin
    unique case (cnt)
      3'd1:       addend = {58'b0, prod};
      3'd2, 3'd3: addend = {26'b0, prod, 32'b0};
      3'd4:       addend = {prod[57:0], 64'b0};
      default:    addend = '0;
    endcase
  end

  // second fold: at most one carry, result never above the modulus
  assign fold_r = fold_s[60:0] + {60'b0, fold_s[61]};

  // sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= STEP_FIRST;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= STEP_FIRST;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == STEP_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end
    if (busy) begin
      prod <= op_x * op_y;
      if (cnt == STEP_FIRST) begin
        acc <= '0;
      end else begin
        acc <= acc + addend;
      end
      // 2^61 = 1 mod p, so the high part adds onto the low part
      if (cnt == STEP_FOLD) begin
        fold_s <= {1'b0, acc[60:0]} + {1'b0, acc[121:61]};
      end
      if (cnt == STEP_LAST) begin
        result <= (fold_r == m61rh_pkg::HASH_MOD) ? '0 : fold_r;
      end
    end
  end

endmodule

### rtl/m61rh_front.sv
// front end: takes items, tracks string length, classifies and queues commands
module m61rh_front #(
  parameter int MAX_LEN = m61rh_pkg::MAX_LEN_DEFAULT,
  localparam int IDX_W  = $clog2(MAX_LEN + 1)
) (
  input  logic                                               clk,
  input  logic                                               rst,
  input  logic                                               item_valid,
  output logic                                               item_stall,
  input  m61rh_pkg::item_t                                   item,
  input  logic                                               queue_full,
  output logic                                               push,
  output m61rh_pkg::cmd_meta_t                               meta,
  output logic [m61rh_pkg::ADDR_SLOTS-1:0][IDX_W-1:0]        addrs
);

  localparam int CMP_W = (IDX_W > m61rh_pkg::LEN_FIELD_W) ? IDX_W : m61rh_pkg::LEN_FIELD_W;

  logic [IDX_W-1:0]             length;
  logic [IDX_W-1:0]             length_next;
  logic [CMP_W-1:0]             len_c;
  logic [CMP_W-1:0]             st_c;
  logic [CMP_W-1:0]             en_c;
  logic [m61rh_pkg::HASH_W-1:0] sym_value;

  assign len_c = CMP_W'(length);
  assign st_c  = CMP_W'(item.start_index);
  assign en_c  = CMP_W'(item.end_index);

  // byte minus offset, taken modulo p
  assign sym_value = (item.symbol >= m61rh_pkg::SYMBOL_OFFSET)
                   ? m61rh_pkg::HASH_W'(item.symbol - m61rh_pkg::SYMBOL_OFFSET)
                   : m61rh_pkg::HASH_MOD
                     - m61rh_pkg::HASH_W'(m61rh_pkg::SYMBOL_OFFSET - item.symbol);

  // classification; refused items become plain results with error set
  always_comb begin
    meta.kind   = m61rh_pkg::KIND_PLAIN;
    meta.error  = 1'b1;
    meta.value  = sym_value;
    length_next = length;
    addrs       = '0;
    unique case (item.opcode)
      m61rh_pkg::OP_APPEND: begin
        if (len_c < CMP_W'(MAX_LEN)) begin
          meta.kind                 = m61rh_pkg::KIND_APPEND;
          meta.error                = 1'b0;
          addrs[m61rh_pkg::ADDR_H0] = length;
          addrs[m61rh_pkg::ADDR_P]  = length;
          addrs[m61rh_pkg::ADDR_H1] = length + IDX_W'(1);
          length_next               = length + IDX_W'(1);
        end
      end
      m61rh_pkg::OP_QUERY: begin
        if (st_c <= en_c && en_c <= len_c) begin
          meta.kind                 = m61rh_pkg::KIND_QUERY;
          meta.error                = 1'b0;
          addrs[m61rh_pkg::ADDR_H0] = IDX_W'(st_c);
          addrs[m61rh_pkg::ADDR_P]  = IDX_W'(en_c - st_c);
          addrs[m61rh_pkg::ADDR_H1] = IDX_W'(en_c);
        end
      end
      m61rh_pkg::OP_CLEAR: begin
        meta.error  = 1'b0;
        length_next = '0;
      end
      default: begin
        meta.error = 1'b1;
      end
    endcase
    meta.length = m61rh_pkg::LEN_FIELD_W'(length_next);
  end

  // handshake toward the queue
  assign push       = item_valid && !queue_full;
  assign item_stall = queue_full;

  // string length as seen by accepted items
  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
    end else if (push) begin
      length <= length_next;
    end
  end

endmodule

### rtl/m61rh_back.sv
// back end: table memories, modular multiply sequencing and the result register
module m61rh_back #(
  parameter int MAX_LEN = m61rh_pkg::MAX_LEN_DEFAULT,
  localparam int IDX_W  = $clog2(MAX_LEN + 1)
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic [m61rh_pkg::HASH_W-1:0]                  base,
  input  logic                                          queue_empty,
  input  m61rh_pkg::cmd_meta_t                          head_meta,
  input  logic [m61rh_pkg::ADDR_SLOTS-1:0][IDX_W-1:0]   head_addrs,
  output logic                                          pop,
  output logic                                          result_valid,
  input  logic                                          result_stall,
  output m61rh_pkg::result_t                            result
);

  localparam int HW = m61rh_pkg::HASH_W;

  m61rh_pkg::back_state_t state;
  m61rh_pkg::back_state_t state_next;

  m61rh_pkg::cmd_meta_t                        cmd_meta;
  logic [m61rh_pkg::ADDR_SLOTS-1:0][IDX_W-1:0] cmd_addrs;

  logic [HW-1:0] hash_mem [0:MAX_LEN];
  logic [HW-1:0] pow_mem  [0:MAX_LEN];
  logic [HW-1:0] h_rdata;
  logic [HW-1:0] p_rdata;
  logic          h_zero;
  logic          p_zero;
  logic [HW-1:0] h_rd;
  logic [HW-1:0] p_rd;

  logic             h_re;
  logic             p_re;
  logic [IDX_W-1:0] h_raddr;
  logic [IDX_W-1:0] p_raddr;
  logic             mem_we;
  logic             out_free;
  logic             out_load;
  logic             h_load;
  logic             p_load;
  logic [HW-1:0]    h_res;
  logic [HW-1:0]    h_res_next;
  logic [HW-1:0]    p_res;

  logic          mul_start;
  logic [HW-1:0] mul_a;
  logic [HW-1:0] mul_b;
  logic          mul_done;
  logic [HW-1:0] mul_result;

  function automatic logic [HW-1:0] add_mod(input logic [HW-1:0] x, input logic [HW-1:0] y);
    logic [HW:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m61rh_pkg::HASH_MOD}) begin
      s = s - {1'b0, m61rh_pkg::HASH_MOD};
    end
    return s[HW-1:0];
  endfunction

  function automatic logic [HW-1:0] sub_mod(input logic [HW-1:0] x, input logic [HW-1:0] y);
    logic [HW:0] d;
    d = {1'b0, x} - {1'b0, y};
    if (x < y) begin
      d = d + {1'b0, m61rh_pkg::HASH_MOD};
    end
    return d[HW-1:0];
  endfunction

  m61rh_mulmod u_mulmod (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (mul_result)
  );

  // entry 0 is never written: it reads as H[0] = 0 and P[0] = 1
  assign h_rd = h_zero ? '0 : h_rdata;
  assign p_rd = p_zero ? HW'(1) : p_rdata;

  assign out_free = !result_valid || !result_stall;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      m61rh_pkg::BK_IDLE: begin
        if (!queue_empty) begin
          if (head_meta.kind == m61rh_pkg::KIND_APPEND
              || head_meta.kind == m61rh_pkg::KIND_QUERY) begin
            state_next = m61rh_pkg::BK_READ;
          end else begin
            state_next = m61rh_pkg::BK_FINISH;
          end
        end
      end
      m61rh_pkg::BK_READ: begin
        state_next = m61rh_pkg::BK_MUL_H;
      end
      m61rh_pkg::BK_MUL_H: begin
        if (mul_done) begin
          state_next = (cmd_meta.kind == m61rh_pkg::KIND_APPEND)
                     ? m61rh_pkg::BK_MUL_P : m61rh_pkg::BK_FINISH;
        end
      end
      m61rh_pkg::BK_MUL_P: begin
        if (mul_done) begin
          state_next = m61rh_pkg::BK_FINISH;
        end
      end
      m61rh_pkg::BK_FINISH: begin
        if (out_free) begin
          state_next = m61rh_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = m61rh_pkg::BK_IDLE;
      end
    endcase
  end

  // per-state controls
  always_comb begin
    pop        = 1'b0;
    h_re       = 1'b0;
    p_re       = 1'b0;
    h_raddr    = head_addrs[m61rh_pkg::ADDR_H0];
    p_raddr    = head_addrs[m61rh_pkg::ADDR_P];
    mul_start  = 1'b0;
    mul_a      = h_rd;
    mul_b      = base;
    h_load     = 1'b0;
    h_res_next = add_mod(mul_result, cmd_meta.value);
    p_load     = 1'b0;
    mem_we     = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      m61rh_pkg::BK_IDLE: begin
        if (!queue_empty) begin
          pop  = 1'b1;
          h_re = 1'b1;
          p_re = 1'b1;
        end
      end
      m61rh_pkg::BK_READ: begin
        mul_start = 1'b1;
        if (cmd_meta.kind == m61rh_pkg::KIND_QUERY) begin
          // prefix at the start times the power of the length
          mul_b   = p_rd;
          h_re    = 1'b1;
          h_raddr = cmd_addrs[m61rh_pkg::ADDR_H1];
        end
      end
      m61rh_pkg::BK_MUL_H: begin
        if (mul_done) begin
          h_load = 1'b1;
          if (cmd_meta.kind == m61rh_pkg::KIND_APPEND) begin
            mul_start = 1'b1;
            mul_a     = p_rd;
          end else begin
            h_res_next = sub_mod(h_rd, mul_result);
          end
        end
      end
      m61rh_pkg::BK_MUL_P: begin
        p_load = mul_done;
      end
      m61rh_pkg::BK_FINISH: begin
        if (out_free) begin
          out_load = 1'b1;
          mem_we   = (cmd_meta.kind == m61rh_pkg::KIND_APPEND);
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= m61rh_pkg::BK_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // command, partial results and the output register
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_meta  <= head_meta;
      cmd_addrs <= head_addrs;
    end
    if (h_load) begin
      h_res <= h_res_next;
    end
    if (p_load) begin
      p_res <= mul_result;
    end
    if (out_load) begin
      result.hash_value    <= (cmd_meta.kind == m61rh_pkg::KIND_PLAIN) ? '0 : h_res;
      result.error         <= cmd_meta.error;
      result.string_length <= cmd_meta.length;
    end
  end

  // prefix hash and base power tables
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hash_mem[cmd_addrs[m61rh_pkg::ADDR_H1]] <= h_res;
      pow_mem[cmd_addrs[m61rh_pkg::ADDR_H1]]  <= p_res;
    end
    if (h_re) begin
      h_rdata <= hash_mem[h_raddr];
      h_zero  <= (h_raddr == '0);
    end
    if (p_re) begin
      p_rdata <= pow_mem[p_raddr];
      p_zero  <= (p_raddr == '0);
    end
  end

endmodule

### rtl/mersenne61_rolling_hash_unit.sv
// Polynomial rolling hash modulo 2^61-1 over a string of up to MAX_LEN bytes. An append
// item stores the next prefix hash and base power and returns the new prefix hash; a query
// returns the hash of symbols start_index up to end_index (exclusive); a clear empties the
// string. Each item gives exactly one result; refused items (bad query range, full table,
// unused opcode) return error set and hash zero. The front takes an item in any cycle that
// the two-entry command queue has room, so up to two items can wait behind the one being
// worked. The back works one command at a time: a clear or a refused item needs no product,
// a query one and an append two, each 61-bit modular product built by the single 32x32
// multiplier from four partial products, after registered table reads. The tables need no
// clearing pass after reset. hash_base is written through base_write/base_value and applies
// to later appends; it resets to 131. The user must write it only while no item is in
// flight; the block itself does not enforce this.
module mersenne61_rolling_hash_unit #(
  parameter int MAX_LEN = m61rh_pkg::MAX_LEN_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  m61rh_pkg::item_t             item,
  output logic                         result_valid,
  input  logic                         result_stall,
  output m61rh_pkg::result_t           result,
  input  logic                         base_write,
  input  logic [m61rh_pkg::HASH_W-1:0] base_value
);

  localparam int IDX_W  = $clog2(MAX_LEN + 1);
  localparam int CMD_W  = m61rh_pkg::META_W + m61rh_pkg::ADDR_SLOTS * IDX_W;

  logic [m61rh_pkg::HASH_W-1:0]                base;
  logic                                        push;
  logic                                        queue_full;
  logic                                        queue_empty;
  logic                                        pop;
  m61rh_pkg::cmd_meta_t                        push_meta;
  logic [m61rh_pkg::ADDR_SLOTS-1:0][IDX_W-1:0] push_addrs;
  m61rh_pkg::cmd_meta_t                        head_meta;
  logic [m61rh_pkg::ADDR_SLOTS-1:0][IDX_W-1:0] head_addrs;
  logic [CMD_W-1:0]                            queue_wdata;
  logic [CMD_W-1:0]                            queue_rdata;

  // hash base register
  always_ff @(posedge clk) begin
    if (rst) begin
      base <= m61rh_pkg::BASE_RESET;
    end else if (base_write) begin
      base <= base_value;
    end
  end

  m61rh_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .queue_full (queue_full),
    .push       (push),
    .meta       (push_meta),
    .addrs      (push_addrs)
  );

  // queue word: addresses above the command fields
  assign queue_wdata             = {push_addrs, push_meta};
  assign {head_addrs, head_meta} = queue_rdata;

  m61rh_fifo #(
    .DATA_W (CMD_W),
    .DEPTH  (m61rh_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (queue_wdata),
    .full  (queue_full),
    .pop   (pop),
    .rdata (queue_rdata),
    .empty (queue_empty)
  );

  m61rh_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .base         (base),
    .queue_empty  (queue_empty),
    .head_meta    (head_meta),
    .head_addrs   (head_addrs),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

### rtl/m61rh_checker.sv
// port-level checker of the rolling hash unit and its bind
`include "mersenne61_rolling_hash_unit_defines.svh"

module m61rh_checker #(
  parameter int MAX_LEN = m61rh_pkg::MAX_LEN_DEFAULT
) (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_stall,
  input logic               result_valid,
  input logic               result_stall,
  input m61rh_pkg::result_t result
);

  logic [3:0] pending;
  logic       item_xfer;
  logic       result_xfer;

  assign item_xfer   = item_valid && !item_stall;
  assign result_xfer = result_valid && !result_stall;

  // items taken but whose result has not been transferred yet
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (item_xfer && !result_xfer) begin
      pending <= pending + 4'd1;
    end else if (result_xfer && !item_xfer) begin
      pending <= pending - 4'd1;
    end
  end

  `M61RH_ASSERT_NOW(a_result_has_item, result_valid, pending != 4'd0, "result without an item")
  `M61RH_ASSERT_NOW(a_error_zero_hash, result_valid && result.error,
                    result.hash_value == '0, "refused item with nonzero hash")
  `M61RH_ASSERT_NOW(a_hash_reduced, result_valid,
                    result.hash_value != m61rh_pkg::HASH_MOD, "hash not reduced")
  `M61RH_ASSERT_NOW(a_length_bound, result_valid,
                    int'(result.string_length) <= MAX_LEN, "length above table size")
  `M61RH_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
                     result_valid && $stable(result), "stalled result changed")

endmodule

bind mersenne61_rolling_hash_unit m61rh_checker #(
  .MAX_LEN (MAX_LEN)
) u_m61rh_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
